/* rtl/core/nss_pkg.sv */
package nss_pkg;

   // Needle capacity of the configuration registers
   localparam int MAX_NEEDLE_DEF = 16;
   localparam int NEEDLE_W       = 128;
   localparam int LEN_W          = 5;
   localparam int CNT_W          = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEEDLE_LEN  = 2'd2;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;

   typedef logic [NEEDLE_W-1:0] needle_type;

   // Controls for the history cells
   typedef struct packed {
      logic advance;
      logic flush;
   } cell_ctl_type;

   // One result beat
   typedef struct packed {
      logic             match_found;
      logic [CNT_W-1:0] match_start;
      logic [CNT_W-1:0] match_total;
      logic             result_last;
   } result_type;

   // Pick needle byte idx, byte 0 in the lowest bits
   function automatic logic [7:0] needle_byte(input needle_type needle,
                                              input logic [3:0] idx);
      logic [7:0] b;
      b = needle[{idx, 3'b000} +: 8];
      return b;
   endfunction

endpackage

/* rtl/core/nss_cell.sv */
module nss_cell #(
   parameter int POS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  nss_pkg::cell_ctl_type  ctl,
   input  logic [7:0]             byte_prev,
   input  nss_pkg::needle_type    needle,
   input  logic [nss_pkg::LEN_W-1:0] len,
   output logic [7:0]             byte_out,
   output logic                   eq
);

   // Cell POS holds the byte POS+1 beats back; it faces needle byte len-2-POS
   localparam logic [nss_pkg::LEN_W:0] REACH = (nss_pkg::LEN_W+1)'(POS + 2);

   logic [7:0]               byte_ff;
   logic [7:0]               byte_in;
   logic                     needed;
   logic [nss_pkg::LEN_W-1:0] idx_full;

   // Shift from the neighbor, flush at the end of a text
   always_comb begin
      byte_in = byte_ff;
      if (ctl.flush) begin
         byte_in = 8'd0;
      end else if (ctl.advance) begin
         byte_in = byte_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   // Compare against the needle byte this cell lines up with
   assign needed   = {1'b0, len} >= REACH;
   assign idx_full = len - REACH[nss_pkg::LEN_W-1:0];
   assign eq       = !needed ||
                     (byte_ff == nss_pkg::needle_byte(needle, idx_full[3:0]));
   assign byte_out = byte_ff;

endmodule

/* rtl/core/nss_outbuf.sv */
module nss_outbuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  nss_pkg::result_type in_data,
   output logic                in_ready,
   output logic                out_valid,
   output nss_pkg::result_type out_data,
   input  logic                out_ready
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   nss_pkg::result_type out_data_ff, out_data_in;
   nss_pkg::result_type skid_data_ff, skid_data_in;
   logic                take;

   assign in_ready  = !skid_valid_ff;
   assign take      = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Output register with one skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            out_data_in = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (out_valid_ff) begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* rtl/core/nonoverlap_substring_scanner.sv */
// Streaming scanner for a needle of up to MAX_NEEDLE bytes: one text byte per
// req beat, one rsp beat per req beat, in order. It sustains one byte per clock
// while rsp is not stalled; the result of a beat is then on rsp the cycle after it is
// accepted. The window compare is a row of MAX_NEEDLE-1 history cells that shift
// one place per accepted beat, each comparing its byte with the needle byte it
// lines up with, so a match of any length is seen as its last byte is accepted. Matches are
// leftmost and non-overlapping: after a hit, the next length-1 bytes cannot hit.
// Offset and count saturate and restart after the beat with req_tlast set. The
// output side has a two-entry buffer, so req_tready drops only when both are
// full. Program the needle while the stream is idle; length 0 disables matching.
module nonoverlap_substring_scanner #(
   parameter int MAX_NEEDLE = nss_pkg::MAX_NEEDLE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: text_byte[7:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [nss_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   // rsp_tdata: match_found[0], match_start[32:1], match_total[64:33], zeros
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [nss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CW = nss_pkg::CNT_W;
   localparam int LW = nss_pkg::LEN_W;
   localparam logic [LW-1:0] MAX_LEN  = LW'(MAX_NEEDLE);
   localparam logic [LW-1:0] SEEN_MAX = '1;
   localparam logic [CW-1:0] CNT_MAX  = '1;

   // Configuration registers
   logic [nss_pkg::CSR_DATA_W-1:0] needle_low_ff, needle_high_ff;
   logic [LW-1:0]                  needle_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         needle_len_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            nss_pkg::CSR_NEEDLE_LOW:  needle_low_ff  <= csr_wdata;
            nss_pkg::CSR_NEEDLE_HIGH: needle_high_ff <= csr_wdata;
            nss_pkg::CSR_NEEDLE_LEN:  needle_len_ff  <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   nss_pkg::needle_type needle;
   logic [LW-1:0]       len;

   // Clamp the length to what the cell row covers
   assign needle = {needle_high_ff, needle_low_ff};
   assign len    = (needle_len_ff > MAX_LEN) ? MAX_LEN : needle_len_ff;

   // Text state
   logic [CW-1:0] offset_ff, offset_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] blocked_ff, blocked_in;
   logic [LW-1:0] seen_ff, seen_in;

   logic                  accept;
   logic [7:0]            cur;
   nss_pkg::cell_ctl_type cell_ctl;

   assign accept         = req_tvalid && req_tready;
   assign cur            = req_tdata[7:0];
   assign cell_ctl.advance = accept;
   assign cell_ctl.flush   = accept && req_tlast;

   // History row: link[0] is the incoming byte, link[k+1] the byte in cell k
   logic [7:0]            link [MAX_NEEDLE];
   logic [MAX_NEEDLE-1:0] hist_eq;

   assign link[0]               = cur;
   assign hist_eq[MAX_NEEDLE-1] = 1'b1;

   for (genvar k = 0; k < MAX_NEEDLE - 1; k++) begin : g_cell
      nss_cell #(
         .POS(k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .byte_prev(link[k]),
         .needle   (needle),
         .len      (len),
         .byte_out (link[k+1]),
         .eq       (hist_eq[k])
      );
   end

   // Window match, then the overlap block
   logic          enough;
   logic          cur_eq;
   logic          hit;
   logic [LW-1:0] len_m1;

   assign len_m1 = len - LW'(1);
   assign enough = ({1'b0, seen_ff} + (LW+1)'(1)) >= {1'b0, len};
   assign cur_eq = nss_pkg::needle_byte(needle, len_m1[3:0]) == cur;
   assign hit    = (len != '0) && enough && cur_eq && (&hist_eq) && (blocked_ff == '0);

   nss_pkg::result_type res;

   always_comb begin
      blocked_in = blocked_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      seen_in    = seen_ff;
      if (blocked_ff != '0) begin
         blocked_in = blocked_ff - LW'(1);
      end
      if (hit) begin
         blocked_in = len_m1;
         if (count_ff != CNT_MAX) begin
            count_in = count_ff + CW'(1);
         end
      end
      res.match_found = hit;
      res.match_start = hit ? (offset_ff - CW'(len_m1)) : '0;
      res.match_total = count_in;
      res.result_last = req_tlast;
      // Restart at the end of a text, otherwise advance saturating
      if (req_tlast) begin
         blocked_in = '0;
         count_in   = '0;
         offset_in  = '0;
         seen_in    = '0;
      end else begin
         if (offset_ff != CNT_MAX) begin
            offset_in = offset_ff + CW'(1);
         end
         if (seen_ff != SEEN_MAX) begin
            seen_in = seen_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         count_ff   <= '0;
         blocked_ff <= '0;
         seen_ff    <= '0;
      end else if (accept) begin
         offset_ff  <= offset_in;
         count_ff   <= count_in;
         blocked_ff <= blocked_in;
         seen_ff    <= seen_in;
      end
   end

   // Output buffer
   nss_pkg::result_type rsp_res;

   nss_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (res),
      .in_ready (req_tready),
      .out_valid(rsp_tvalid),
      .out_data (rsp_res),
      .out_ready(rsp_tready)
   );

   assign rsp_tdata = {7'd0, rsp_res.match_total, rsp_res.match_start, rsp_res.match_found};
   assign rsp_tlast = rsp_res.result_last;

   // Checks
   a_found_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[64:33] != '0)
      else $error("match reported with zero total");

   a_blocked_range: assert property (@(posedge clock) disable iff (reset)
      blocked_ff < MAX_LEN)
      else $error("overlap block longer than the needle");

   a_text_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> offset_ff == '0 && count_ff == '0 && seen_ff == '0)
      else $error("text state not cleared after last beat");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

endmodule

/* sim/nonoverlap_substring_scanner_tb.sv */
module nonoverlap_substring_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 8;
   localparam int NEEDLE_MAX  = 16;
   localparam int ITEM_TARGET = 1900;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } text_beat_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [nss_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [nss_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_we     = 1'b0;
   logic [nss_pkg::CSR_IDX_W-1:0]  csr_index  = nss_pkg::CSR_NEEDLE_LOW;
   logic [nss_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // Text bytes waiting to be sent, scan results waiting to be seen
   text_beat_type       pending_text[$];
   nss_pkg::result_type expected_scan[$];

   // Scanner shadow: configuration and per-text state
   logic [nss_pkg::NEEDLE_W-1:0] needle_bits = '0;
   logic [nss_pkg::LEN_W-1:0]    needle_len  = '0;
   logic [7:0]          history [0:NEEDLE_MAX-2];
   logic [31:0]         text_offset = '0;
   logic [31:0]         hit_count   = '0;
   logic [4:0]          skip_left   = '0;
   logic [4:0]          seen_count  = '0;

   int          mismatch_count = 0;
   int          pushed         = 0;
   int          send_gap       = 0;
   int          sink_gap       = 0;
   int          hold_left      = 0;
   int          hold_asked     = 0;
   int          hold_done      = 0;
   bit          calm           = 1'b0;
   logic        req_taken      = 1'b0;
   int unsigned cycle_count    = 0;

   nonoverlap_substring_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Clear the per-text state at the start and after each closing byte
   task automatic restart_text();
      for (int k = 0; k < NEEDLE_MAX - 1; k++) history[k] = 8'h00;
      text_offset = '0;
      hit_count   = '0;
      skip_left   = '0;
      seen_count  = '0;
   endtask

   // Advance the shadow by one text byte and queue the result it must give
   task automatic scan_byte(input logic [7:0] cur, input logic last);
      nss_pkg::result_type res;
      int         len;
      bit         hit;
      len = (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
      hit = 1'b0;
      if (len > 0 && int'(seen_count) + 1 >= len) begin
         hit = (needle_bits[8*(len-1) +: 8] == cur);
         for (int k = 0; k + 1 < len; k++) begin
            if (history[len-2-k] != needle_bits[8*k +: 8]) hit = 1'b0;
         end
      end
      // Drop anything that ends inside the previous occurrence
      if (skip_left != 0) begin
         hit = 1'b0;
         skip_left--;
      end
      res = '0;
      if (hit) begin
         res.match_start = text_offset - 32'(len - 1);
         if (hit_count != SAT_MAX) hit_count++;
         skip_left = 5'(len - 1);
      end
      res.match_found = hit;
      res.match_total = hit_count;
      res.result_last = last;
      expected_scan = {expected_scan, res};
      if (last) begin
         restart_text();
      end else begin
         for (int k = NEEDLE_MAX - 2; k > 0; k--) history[k] = history[k-1];
         history[0] = cur;
         if (text_offset != SAT_MAX) text_offset++;
         if (seen_count != 5'd31) seen_count++;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s: expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Predict on each accepted text beat, then check each result beat
   always @(posedge clock) begin : scoreboard
      nss_pkg::result_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_scan.size() == 0) begin
            $display("%0t result beat with none pending: 0x%0h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_scan.pop_front();
            check_field("match_found", 32'(want.match_found), 32'(rsp_tdata[0]));
            check_field("match_start", want.match_start, rsp_tdata[32:1]);
            check_field("match_total", want.match_total, rsp_tdata[64:33]);
            check_field("result_last", 32'(want.result_last), 32'(rsp_tlast));
         end
      end
   end

   // Text driver: hold the beat until taken, then load the next after any gap
   always @(negedge clock) begin : text_driver
      text_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_text.size() > 0) begin
            beat = pending_text.pop_front();
            req_tdata  <= beat.text_byte;
            req_tlast  <= beat.text_end;
            req_tvalid <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result sink: short random stalls, plus a long hold on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_done != hold_asked) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 10);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("nonoverlap_substring_scanner_tb: errors");
      $finish;
   end

   task automatic push_beat(input logic [7:0] b, input logic last);
      text_beat_type beat;
      beat.text_byte = b;
      beat.text_end  = last;
      pending_text = {pending_text, beat};
      pushed++;
   endtask

   // Queue one copy of the needle, or a copy with one byte flipped or cut short
   task automatic push_copy(input int e, input logic [nss_pkg::NEEDLE_W-1:0] nb,
                            input bit broken);
      int         cut;
      logic [7:0] b;
      cut = broken ? int'($urandom_range(0, e - 1)) : e;
      for (int k = 0; k < e; k++) begin
         b = nb[8*k +: 8];
         if (k == cut) begin
            if ($urandom_range(0, 1) != 0) break;
            b = b ^ (8'h01 << $urandom_range(0, 7));
         end
         push_beat(b, $urandom_range(0, 59) == 0);
      end
   endtask

   task automatic write_reg(input logic [nss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nss_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         nss_pkg::CSR_NEEDLE_LOW:  needle_bits[63:0]   = val;
         nss_pkg::CSR_NEEDLE_HIGH: needle_bits[127:64] = val;
         nss_pkg::CSR_NEEDLE_LEN:  needle_len          = val[nss_pkg::LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_needle(input logic [nss_pkg::NEEDLE_W-1:0] nb,
                             input logic [nss_pkg::CSR_DATA_W-1:0] len_word);
      write_reg(nss_pkg::CSR_NEEDLE_LOW, nb[63:0]);
      write_reg(nss_pkg::CSR_NEEDLE_HIGH, nb[127:64]);
      write_reg(nss_pkg::CSR_NEEDLE_LEN, len_word);
   endtask

   // Wait until every queued byte is taken and every result has come back
   task automatic wait_drain();
      do @(posedge clock);
      while (pending_text.size() != 0 || req_tvalid || expected_scan.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [nss_pkg::NEEDLE_W-1:0]   nbits;
      logic [nss_pkg::CSR_DATA_W-1:0] len_word;
      logic [7:0]            b0, b1;
      int                    nlen, e, phase, n_items, first;
      restart_text();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty needle after reset: nothing may match
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b1);
      wait_drain();

      // Single byte needle: every copy matches, no skipping
      set_needle({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 64'd1);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b1);
      wait_drain();

      // Two zero bytes: short text on the first byte, then match, skip, match, skip
      set_needle({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 64'd2);
      write_reg(nss_pkg::CSR_NEEDLE_LOW, 64'h0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b1);
      wait_drain();

      // Length above the capacity, junk in the upper write bits: acts as 16
      set_needle({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 64'hFFFF_FFFF_FFFF_FFF4);
      repeat (8) push_beat(8'h00, 1'b0);
      repeat (7) push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b1);
      wait_drain();

      // Random phases; a text may run on across a needle change
      phase = 0;
      while (pushed < ITEM_TARGET) begin
         b0 = 8'($urandom);
         b1 = 8'($urandom);
         case ($urandom_range(0, 3))
            0: nbits = {$urandom, $urandom, $urandom, $urandom};
            1: nbits = {16{b0}};
            2: nbits = {8{b1, b0}};
            default: begin
               for (int k = 0; k < NEEDLE_MAX; k++)
                  nbits[8*k +: 8] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
         endcase
         case ($urandom_range(0, 9))
            0: nlen = 0;
            1: nlen = $urandom_range(17, 31);
            2: nlen = NEEDLE_MAX;
            default: nlen = $urandom_range(1, 6);
         endcase
         if (phase == 0) begin
            nbits = '1;
            nlen  = NEEDLE_MAX;
         end else if (phase == 1) begin
            nlen = 31;
         end else if (phase == 2) begin
            nlen = 0;
         end
         len_word = {$urandom, $urandom};
         if ($urandom_range(0, 1) != 0) len_word[nss_pkg::CSR_DATA_W-1:nss_pkg::LEN_W] = '0;
         len_word[nss_pkg::LEN_W-1:0] = nlen[nss_pkg::LEN_W-1:0];
         set_needle(nbits, len_word);

         calm = (phase % 6 == 5) || (pushed >= ITEM_TARGET - 300);
         if (phase == 3) hold_asked++;

         n_items = $urandom_range(20, 70);
         first   = pushed;
         while (pushed - first < n_items) begin
            e = (nlen > NEEDLE_MAX) ? NEEDLE_MAX : nlen;
            if (e == 0) e = $urandom_range(1, 4);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: push_copy(e, nbits, 1'b0);
               6, 7: push_copy(e, nbits, 1'b1);
               8: begin
                  repeat ($urandom_range(1, 4))
                     push_beat(nbits[8*$urandom_range(0, 15) +: 8],
                               $urandom_range(0, 59) == 0);
               end
               default: push_beat(8'($urandom), $urandom_range(0, 59) == 0);
            endcase
         end
         wait_drain();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_scan.size() == 0) begin
         $display("nonoverlap_substring_scanner_tb: clean");
      end else begin
         $display("nonoverlap_substring_scanner_tb: errors");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/nss_pkg.sv
rtl/core/nss_cell.sv
rtl/core/nss_outbuf.sv
rtl/core/nonoverlap_substring_scanner.sv
sim/nonoverlap_substring_scanner_tb.sv
